// ----- hdl/pldt_pkg.sv -----
// Package: shared types, constants and helpers of the path latency delta tracker.
`timescale 1ns / 1ps
`default_nettype none

package pldt_pkg;

    // Number of tracked paths and derived storage sizes
    localparam int NUM_PATHS = 8;
    localparam int PATH_W    = (NUM_PATHS > 1) ? $clog2(NUM_PATHS) : 1;
    localparam int MAT_DEPTH = NUM_PATHS * NUM_PATHS;
    localparam int MAT_AW    = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;

    // Field widths
    localparam int PATH_IN_W = 8;
    localparam int TIME_W    = 64;
    localparam int SECS_W    = 32;
    localparam int USEC_W    = 20;
    localparam int DELTA_W   = 32;
    localparam int MAX_W     = 31;

    // Microseconds per second
    localparam logic [USEC_W-1:0] USEC_PER_SEC = 20'd1000000;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_SUB,
        ST_ROW,
        ST_COL,
        ST_SCAN,
        ST_LAST
    } pldt_state_t;

    // Shared unit operations
    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t            op;
        logic [TIME_W-1:0]  a;
        logic [TIME_W-1:0]  b;
    } alu_req_t;

    typedef struct packed {
        logic [TIME_W-1:0]  result;
        logic               borrow;
    } alu_res_t;

    // Difference matrix write request
    typedef struct packed {
        logic               en;
        logic [MAT_AW-1:0]  addr;
        logic [DELTA_W-1:0] data;
    } dmem_wr_t;

    // Flat matrix address of entry [row][col]
    function automatic logic [MAT_AW-1:0] mat_addr(input logic [PATH_W-1:0] row,
                                                   input logic [PATH_W-1:0] col);
        logic [MAT_AW-1:0] base;
        base = MAT_AW'(row) * MAT_AW'(NUM_PATHS);
        return base + MAT_AW'(col);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/pldt_alu.sv -----
// Shared arithmetic unit: constant multiply, add, and subtract with borrow.
`timescale 1ns / 1ps
`default_nettype none

module pldt_alu (
    input  wire pldt_pkg::alu_req_t req,
    output pldt_pkg::alu_res_t      res
);

    logic [51:0]                 prod;
    logic [pldt_pkg::TIME_W:0]   wide;

    // Scale seconds by one million
    assign prod = req.a[pldt_pkg::SECS_W-1:0] * pldt_pkg::USEC_PER_SEC;

    // Select the operation
    always_comb begin
        case (req.op)
            pldt_pkg::ALU_MUL: wide = {1'b0, 12'd0, prod};
            pldt_pkg::ALU_ADD: wide = {1'b0, req.a} + {1'b0, req.b};
            pldt_pkg::ALU_SUB: wide = {1'b0, req.a} - {1'b0, req.b};
            default:           wide = '0;
        endcase
    end

    assign res.result = wide[pldt_pkg::TIME_W-1:0];
    assign res.borrow = (req.op == pldt_pkg::ALU_SUB) ? wide[pldt_pkg::TIME_W] : 1'b0;

endmodule

`default_nettype wire

// ----- hdl/pldt_dmem.sv -----
// Difference matrix storage: one write port, one registered read port, per-entry valid bits.
`timescale 1ns / 1ps
`default_nettype none

module pldt_dmem (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire pldt_pkg::dmem_wr_t             wr,
    input  wire [pldt_pkg::MAT_AW-1:0]          rd_addr,
    output logic [pldt_pkg::DELTA_W-1:0]        rd_data
);

    logic [pldt_pkg::DELTA_W-1:0] mem [pldt_pkg::MAT_DEPTH];
    logic [pldt_pkg::MAT_DEPTH-1:0] vld_reg;
    logic [pldt_pkg::DELTA_W-1:0] rd_mem_reg;
    logic                         rd_vld_reg;

    // Write entry and read port
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_mem_reg <= mem[rd_addr];
    end

    // Track written entries; reset marks all as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                vld_reg[wr.addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    // Unwritten entries read as zero
    assign rd_data = rd_vld_reg ? rd_mem_reg : '0;

endmodule

`default_nettype wire

// ----- hdl/path_latency_delta_tracker_core.sv -----
// Top level: sequencer, path latency table and result register of the delta tracker.
// An item runs through the MUL, ADD and SUB steps, then a ROW and COL step per path, then a
// scan of every matrix entry; an out-of-range path skips the update walk.
// No new item is accepted until the result is loaded; the shared unit walks up to two matrix
// writes per path, then one matrix read per entry for the maximum.
// Reset clears all path latencies and the matrix valid bits at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module path_latency_delta_tracker_core (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [127:0] s_tdata,   // path_id, source_time_us, arrival_seconds, arrival_micros
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [95:0] m_tdata,   // latency_us, max_delta
    output logic        m_tuser    // path_ignored
);

    pldt_pkg::pldt_state_t state_reg, state_next;

    logic [pldt_pkg::PATH_IN_W-1:0] path_reg;
    logic [pldt_pkg::TIME_W-1:0]    src_reg;
    logic [pldt_pkg::SECS_W-1:0]    secs_reg;
    logic [pldt_pkg::USEC_W-1:0]    usec_reg;
    logic [pldt_pkg::TIME_W-1:0]    acc_reg;
    logic [pldt_pkg::MAX_W-1:0]     best_reg;
    logic [pldt_pkg::PATH_W-1:0]    idx_reg;
    logic [pldt_pkg::MAT_AW-1:0]    scan_reg;
    logic                           cmp_en_reg;

    logic [pldt_pkg::TIME_W-1:0]    lat_tab [pldt_pkg::NUM_PATHS];

    logic                           out_valid_reg;
    logic [pldt_pkg::TIME_W-1:0]    out_lat_reg;
    logic [pldt_pkg::MAX_W-1:0]     out_max_reg;
    logic                           out_ign_reg;

    pldt_pkg::alu_req_t             alu_req;
    pldt_pkg::alu_res_t             alu_res;
    pldt_pkg::dmem_wr_t             mat_wr;
    logic [pldt_pkg::DELTA_W-1:0]   rd_data;

    logic                           accept;
    logic                           path_ok;
    logic [pldt_pkg::PATH_W-1:0]    p_idx;
    logic [pldt_pkg::TIME_W-1:0]    li;
    logic                           idx_last;
    logic                           scan_last;
    logic                           cmp_hit;
    logic                           out_load;
    logic                           lat_wr;

    assign accept    = s_tvalid && s_tready;
    assign path_ok   = path_reg < pldt_pkg::PATH_IN_W'(pldt_pkg::NUM_PATHS);
    assign p_idx     = path_reg[pldt_pkg::PATH_W-1:0];
    assign li        = lat_tab[idx_reg];
    assign idx_last  = idx_reg == pldt_pkg::PATH_W'(pldt_pkg::NUM_PATHS - 1);
    assign scan_last = scan_reg == pldt_pkg::MAT_AW'(pldt_pkg::MAT_DEPTH - 1);
    assign cmp_hit   = cmp_en_reg && alu_res.borrow && !rd_data[pldt_pkg::DELTA_W-1];

    pldt_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    pldt_dmem u_dmem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (mat_wr),
        .rd_addr (scan_reg),
        .rd_data (rd_data)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pldt_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = pldt_pkg::ST_MUL;
                end
            end
            pldt_pkg::ST_MUL:  state_next = pldt_pkg::ST_ADD;
            pldt_pkg::ST_ADD:  state_next = pldt_pkg::ST_SUB;
            pldt_pkg::ST_SUB:  state_next = path_ok ? pldt_pkg::ST_ROW : pldt_pkg::ST_SCAN;
            pldt_pkg::ST_ROW:  state_next = pldt_pkg::ST_COL;
            pldt_pkg::ST_COL:  state_next = idx_last ? pldt_pkg::ST_SCAN : pldt_pkg::ST_ROW;
            pldt_pkg::ST_SCAN: begin
                if (scan_last) begin
                    state_next = pldt_pkg::ST_LAST;
                end
            end
            pldt_pkg::ST_LAST: begin
                if (out_load) begin
                    state_next = pldt_pkg::ST_IDLE;
                end
            end
            default:           state_next = pldt_pkg::ST_IDLE;
        endcase
    end

    // Control outputs and shared unit operands
    always_comb begin
        s_tready     = 1'b0;
        out_load     = 1'b0;
        lat_wr       = 1'b0;
        alu_req.op   = pldt_pkg::ALU_SUB;
        alu_req.a    = {{(pldt_pkg::TIME_W - pldt_pkg::MAX_W){1'b0}}, best_reg};
        alu_req.b    = {{(pldt_pkg::TIME_W - pldt_pkg::DELTA_W){1'b0}}, rd_data};
        mat_wr.en    = 1'b0;
        mat_wr.addr  = pldt_pkg::mat_addr(p_idx, idx_reg);
        mat_wr.data  = alu_res.result[pldt_pkg::DELTA_W-1:0];
        case (state_reg)
            pldt_pkg::ST_IDLE: s_tready = 1'b1;
            pldt_pkg::ST_MUL: begin
                alu_req.op = pldt_pkg::ALU_MUL;
                alu_req.a  = {{(pldt_pkg::TIME_W - pldt_pkg::SECS_W){1'b0}}, secs_reg};
            end
            pldt_pkg::ST_ADD: begin
                alu_req.op = pldt_pkg::ALU_ADD;
                alu_req.a  = acc_reg;
                alu_req.b  = {{(pldt_pkg::TIME_W - pldt_pkg::USEC_W){1'b0}}, usec_reg};
            end
            pldt_pkg::ST_SUB: begin
                alu_req.a = acc_reg;
                alu_req.b = src_reg;
                lat_wr    = path_ok;
            end
            pldt_pkg::ST_ROW: begin
                alu_req.a = acc_reg;
                alu_req.b = li;
                mat_wr.en = li != '0;
            end
            pldt_pkg::ST_COL: begin
                alu_req.a   = li;
                alu_req.b   = acc_reg;
                mat_wr.en   = li != '0;
                mat_wr.addr = pldt_pkg::mat_addr(idx_reg, p_idx);
            end
            pldt_pkg::ST_SCAN: ;
            pldt_pkg::ST_LAST: out_load = !out_valid_reg || m_tready;
            default: ;
        endcase
    end

    // Sequencer control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pldt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Path latency table; reset marks every path empty
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < pldt_pkg::NUM_PATHS; k++) begin
                lat_tab[k] <= '0;
            end
        end else if (lat_wr) begin
            lat_tab[p_idx] <= alu_res.result;
        end
    end

    // Datapath: capture item, hold accumulator, advance counters, track maximum
    always_ff @(posedge aclk) begin
        case (state_reg)
            pldt_pkg::ST_IDLE: begin
                if (accept) begin
                    path_reg <= s_tdata[7:0];
                    src_reg  <= s_tdata[71:8];
                    secs_reg <= s_tdata[103:72];
                    usec_reg <= s_tdata[123:104];
                end
                best_reg   <= '0;
                idx_reg    <= '0;
                scan_reg   <= '0;
                cmp_en_reg <= 1'b0;
            end
            pldt_pkg::ST_MUL, pldt_pkg::ST_ADD, pldt_pkg::ST_SUB: begin
                acc_reg <= alu_res.result;
            end
            pldt_pkg::ST_COL: begin
                idx_reg <= idx_reg + 1'b1;
            end
            pldt_pkg::ST_SCAN: begin
                cmp_en_reg <= 1'b1;
                if (cmp_hit) begin
                    best_reg <= rd_data[pldt_pkg::MAX_W-1:0];
                end
                if (!scan_last) begin
                    scan_reg <= scan_reg + 1'b1;
                end
            end
            pldt_pkg::ST_LAST: begin
                if (cmp_hit) begin
                    best_reg <= rd_data[pldt_pkg::MAX_W-1:0];
                end
            end
            default: ;
        endcase
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_lat_reg <= acc_reg;
            out_max_reg <= cmp_hit ? rd_data[pldt_pkg::MAX_W-1:0] : best_reg;
            out_ign_reg <= !path_ok;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_max_reg, out_lat_reg};
    assign m_tuser  = out_ign_reg;

endmodule

`default_nettype wire
